### rtl/rwdp_pkg.sv
// package for the retention watermark and debt policy unit
// holds sizing constants, command and register codes, and shared structs
// no dependencies
`default_nettype none

package rwdp_pkg;

   localparam int NUM_SHARDS        = 32;
   localparam int SEGMENT_SIZE_LOG2 = 21;

   localparam int SHARD_IDX_W = (NUM_SHARDS > 1) ? $clog2(NUM_SHARDS) : 1;

   localparam int BYTES_W  = 40;
   localparam int DEBT_W   = 16;
   localparam int PHASE_W  = 16;
   localparam int ROUND_W  = 8;
   localparam int LEVEL_W  = 2;
   localparam int CMD_W    = 3;
   localparam int SLOTS_W  = 16;
   localparam int SHARD_W  = 8;
   localparam int LIVE_W   = 8;
   localparam int CSR_IDX_W = 3;

   localparam logic [LEVEL_W-1:0] LEVEL_L0 = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_L1 = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_L2 = 2'd2;

   localparam logic [DEBT_W-1:0] DEBT_MAX = {DEBT_W{1'b1}};

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK  = 3'd0,
      CMD_OPEN  = 3'd1,
      CMD_FREE  = 3'd2,
      CMD_QUERY = 3'd3,
      CMD_EPOCH = 3'd4
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SOFT_THRESHOLD = 3'd0,
      CSR_HARD_THRESHOLD = 3'd1,
      CSR_HYSTERESIS     = 3'd2,
      CSR_DEBT_CAP       = 3'd3,
      CSR_REPAY_INTERVAL = 3'd4,
      CSR_SUBREL_MULT    = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic [BYTES_W-1:0] soft_threshold;
      logic [BYTES_W-1:0] hard_threshold;
      logic [BYTES_W-1:0] hysteresis;
      logic [DEBT_W-1:0]  debt_cap;
      logic [PHASE_W-1:0] repay_interval;
      logic [ROUND_W-1:0] subrelease_multiple;
   } cfg_type;

   // sequencer commands to the datapath
   typedef struct packed {
      logic capture;
      logic prep;
      logic eval;
      logic commit;
   } ctrl_cmd_type;

endpackage

`default_nettype wire

### rtl/rwdp_csr.sv
// configuration registers of the retention policy unit
// depends on rwdp_pkg
`default_nettype none

module rwdp_csr
   import rwdp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [BYTES_W-1:0]   csr_wdata,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SOFT_THRESHOLD: cfg_in.soft_threshold = csr_wdata;
            CSR_HARD_THRESHOLD: cfg_in.hard_threshold = csr_wdata;
            CSR_HYSTERESIS:     cfg_in.hysteresis     = csr_wdata;
            CSR_DEBT_CAP:       cfg_in.debt_cap       = csr_wdata[DEBT_W-1:0];
            CSR_REPAY_INTERVAL: cfg_in.repay_interval = csr_wdata[PHASE_W-1:0];
            CSR_SUBREL_MULT:    cfg_in.subrelease_multiple = csr_wdata[ROUND_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.soft_threshold      <= BYTES_W'(64'd2147483648);
         cfg_ff.hard_threshold      <= BYTES_W'(64'd3221225472);
         cfg_ff.hysteresis          <= BYTES_W'(64'd268435456);
         cfg_ff.debt_cap            <= DEBT_W'(4);
         cfg_ff.repay_interval      <= PHASE_W'(16);
         cfg_ff.subrelease_multiple <= ROUND_W'(4);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### rtl/rwdp_ctrl.sv
// sequencer of the retention policy unit: capture, prep, eval, commit
// depends on rwdp_pkg
`default_nettype none

module rwdp_ctrl
   import rwdp_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   start,
   output logic        busy,
   output ctrl_cmd_type ctrl
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_PREP   = 4'b0010,
      ST_EVAL   = 4'b0100,
      ST_COMMIT = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (start) state_in = ST_PREP;
         ST_PREP:   state_in = ST_EVAL;
         ST_EVAL:   state_in = ST_COMMIT;
         ST_COMMIT: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy         = (state_ff != ST_IDLE);
   assign ctrl.capture = (state_ff == ST_IDLE) && start;
   assign ctrl.prep    = (state_ff == ST_PREP);
   assign ctrl.eval    = (state_ff == ST_EVAL);
   assign ctrl.commit  = (state_ff == ST_COMMIT);

endmodule

`default_nettype wire

### rtl/rwdp_datapath.sv
// datapath of the retention policy unit: level, shard debt, epoch and round phases
// depends on rwdp_pkg
`default_nettype none

module rwdp_datapath
   import rwdp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  ctrl_cmd_type            ctrl,
   input  cfg_type                 cfg,
   input  wire logic [CMD_W-1:0]   req_cmd,
   input  wire logic [SLOTS_W-1:0] req_used_slots,
   input  wire logic [SHARD_W-1:0] req_shard,
   input  wire logic [LIVE_W-1:0]  req_live_count,
   output logic                    rsp_valid,
   output logic [LEVEL_W-1:0]      rsp_level,
   output logic                    rsp_level_changed,
   output logic [DEBT_W-1:0]       rsp_debt_value,
   output logic                    rsp_repay_request,
   output logic                    rsp_epoch_due,
   output logic                    rsp_compact_hard,
   output logic                    rsp_compact_soft,
   output logic                    rsp_reclaim_segments,
   output logic                    rsp_medium_subrelease
);

   // captured item
   logic [CMD_W-1:0]       cmd_ff;
   logic [BYTES_W-1:0]     bytes_ff;
   logic [SHARD_IDX_W-1:0] idx_ff;
   logic                   in_range_ff;
   logic                   coll_ff;

   // prep stage
   logic [DEBT_W-1:0]  debt_rd_ff;
   logic [BYTES_W-1:0] soft_low_ff;
   logic [BYTES_W-1:0] hard_low_ff;

   // eval stage
   logic               ge_hard_ff;
   logic               ge_soft_ff;
   logic               lt_soft_low_ff;
   logic               lt_hard_low_ff;
   logic               debt_gt_ff;
   logic               ep_wrap_ff;
   logic               rp_wrap_ff;
   logic [PHASE_W-1:0] ph_next_ff;
   logic [ROUND_W-1:0] rp_next_ff;

   // architectural state
   logic [LEVEL_W-1:0] level_ff,  level_in;
   logic [PHASE_W-1:0] phase_ff,  phase_in;
   logic [ROUND_W-1:0] round_ff,  round_in;
   logic [DEBT_W-1:0]  debt_ff [NUM_SHARDS];

   logic [DEBT_W-1:0]  debt_new;
   logic               changed, req, due, c_hard, c_soft, reclaim, subrel, debt_we;

   logic [BYTES_W:0]   soft_diff;
   logic [BYTES_W:0]   hard_diff;
   logic               in_range;
   logic [PHASE_W-1:0] iv;
   logic [PHASE_W-1:0] ph_inc;
   logic [ROUND_W-1:0] rp_inc;

   assign in_range  = ({1'b0, req_shard} < (SHARD_W + 1)'(NUM_SHARDS));
   // threshold minus hysteresis, floored at zero via the borrow
   assign soft_diff = {1'b0, cfg.soft_threshold} - {1'b0, cfg.hysteresis};
   assign hard_diff = {1'b0, cfg.hard_threshold} - {1'b0, cfg.hysteresis};
   assign iv        = (cfg.repay_interval == '0) ? PHASE_W'(1) : cfg.repay_interval;
   assign ph_inc    = phase_ff + PHASE_W'(1);
   assign rp_inc    = round_ff + ROUND_W'(1);

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff      <= req_cmd;
         bytes_ff    <= BYTES_W'(req_used_slots) << SEGMENT_SIZE_LOG2;
         idx_ff      <= in_range ? req_shard[SHARD_IDX_W-1:0] : '0;
         in_range_ff <= in_range;
         coll_ff     <= (req_live_count > LIVE_W'(1));
      end
      if (ctrl.prep) begin
         debt_rd_ff  <= debt_ff[idx_ff];
         soft_low_ff <= soft_diff[BYTES_W] ? '0 : soft_diff[BYTES_W-1:0];
         hard_low_ff <= hard_diff[BYTES_W] ? '0 : hard_diff[BYTES_W-1:0];
      end
      if (ctrl.eval) begin
         ge_hard_ff     <= (bytes_ff >= cfg.hard_threshold);
         ge_soft_ff     <= (bytes_ff >= cfg.soft_threshold);
         lt_soft_low_ff <= (bytes_ff < soft_low_ff);
         lt_hard_low_ff <= (bytes_ff < hard_low_ff);
         debt_gt_ff     <= in_range_ff && (debt_rd_ff > cfg.debt_cap);
         ep_wrap_ff     <= (ph_inc >= iv);
         rp_wrap_ff     <= (rp_inc >= cfg.subrelease_multiple);
         ph_next_ff     <= ph_inc;
         rp_next_ff     <= rp_inc;
      end
   end

   always_comb begin
      level_in = level_ff;
      phase_in = phase_ff;
      round_in = round_ff;
      debt_new = debt_rd_ff;
      debt_we  = 1'b0;
      changed  = 1'b0;
      req      = 1'b0;
      due      = 1'b0;
      c_hard   = 1'b0;
      c_soft   = 1'b0;
      reclaim  = 1'b0;
      subrel   = 1'b0;
      case (cmd_ff)
         CMD_TICK: begin
            case (level_ff)
               LEVEL_L0: begin
                  if (ge_hard_ff) level_in = LEVEL_L2;
                  else if (ge_soft_ff) level_in = LEVEL_L1;
               end
               LEVEL_L1: begin
                  if (ge_hard_ff) level_in = LEVEL_L2;
                  else if (lt_soft_low_ff) level_in = LEVEL_L0;
               end
               LEVEL_L2: begin
                  // fall to L0 wins over fall to L1
                  if (lt_soft_low_ff) level_in = LEVEL_L0;
                  else if (lt_hard_low_ff) level_in = LEVEL_L1;
               end
               default: level_in = level_ff;
            endcase
            changed = (level_in != level_ff);
         end
         CMD_OPEN: begin
            debt_we = in_range_ff;
            if (debt_rd_ff != DEBT_MAX) debt_new = debt_rd_ff + DEBT_W'(1);
         end
         CMD_FREE: begin
            debt_we = in_range_ff;
            if (debt_rd_ff != '0) debt_new = debt_rd_ff - DEBT_W'(1);
         end
         CMD_QUERY: begin
            req = (level_ff == LEVEL_L2) && debt_gt_ff;
         end
         CMD_EPOCH: begin
            if (level_ff == LEVEL_L2) begin
               if (ep_wrap_ff) begin
                  phase_in = '0;
                  due      = 1'b1;
                  c_hard   = !coll_ff;
                  c_soft   = coll_ff;
                  reclaim  = !coll_ff;
                  if (cfg.subrelease_multiple == '0 || rp_wrap_ff) begin
                     round_in = '0;
                     subrel   = !coll_ff;
                  end else begin
                     round_in = rp_next_ff;
                  end
               end else begin
                  phase_in = ph_next_ff;
               end
            end
         end
         default: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff  <= LEVEL_L0;
         phase_ff  <= '0;
         round_ff  <= '0;
         rsp_valid <= 1'b0;
         for (int i = 0; i < NUM_SHARDS; i++) begin
            debt_ff[i] <= '0;
         end
      end else begin
         rsp_valid <= ctrl.commit;
         if (ctrl.commit) begin
            level_ff <= level_in;
            phase_ff <= phase_in;
            round_ff <= round_in;
            if (debt_we) debt_ff[idx_ff] <= debt_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.commit) begin
         rsp_level             <= level_in;
         rsp_level_changed     <= changed;
         rsp_debt_value        <= in_range_ff ? debt_new : '0;
         rsp_repay_request     <= req;
         rsp_epoch_due         <= due;
         rsp_compact_hard      <= c_hard;
         rsp_compact_soft      <= c_soft;
         rsp_reclaim_segments  <= reclaim;
         rsp_medium_subrelease <= subrel;
      end
   end

endmodule

`default_nettype wire

### rtl/retention_watermark_debt_policy_unit.sv
// top level of the retention watermark and debt policy unit
// depends on rwdp_pkg, rwdp_csr, rwdp_ctrl and rwdp_datapath
`default_nettype none

// channel    handshake             payload
// --------   -------------------   -------------------------------------------
// request    start / busy          req_cmd req_used_slots req_shard req_live_count
// result     rsp_valid (strobe)    rsp_level rsp_level_changed rsp_debt_value
//                                  rsp_repay_request rsp_epoch_due rsp_compact_*
//                                  rsp_reclaim_segments rsp_medium_subrelease
// config     csr_we                csr_index csr_wdata
//
// an item is taken when start is high and busy is low; it then runs through
// prep (debt read, clamped thresholds), eval (wide compares, phase steps) and
// commit (state update), and its result strobes in the cycle after commit
// a new item is taken only once the four-state sequencer is back in idle
// synchronous active-high reset puts the level at L0, clears all shard debt
// and both phases; the receiver cannot stall, results are held one cycle only

module retention_watermark_debt_policy_unit
   import rwdp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [CMD_W-1:0]     req_cmd,
   input  wire logic [SLOTS_W-1:0]   req_used_slots,
   input  wire logic [SHARD_W-1:0]   req_shard,
   input  wire logic [LIVE_W-1:0]    req_live_count,
   // result
   output logic                      rsp_valid,
   output logic [LEVEL_W-1:0]        rsp_level,
   output logic                      rsp_level_changed,
   output logic [DEBT_W-1:0]         rsp_debt_value,
   output logic                      rsp_repay_request,
   output logic                      rsp_epoch_due,
   output logic                      rsp_compact_hard,
   output logic                      rsp_compact_soft,
   output logic                      rsp_reclaim_segments,
   output logic                      rsp_medium_subrelease,
   // configuration
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [BYTES_W-1:0]   csr_wdata
);

   cfg_type      cfg;
   ctrl_cmd_type ctrl;

   // threshold, hysteresis, limit, interval and multiple registers
   rwdp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // item sequencer
   rwdp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .ctrl  (ctrl)
   );

   // level, debt table and repay phases
   rwdp_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .ctrl                  (ctrl),
      .cfg                   (cfg),
      .req_cmd               (req_cmd),
      .req_used_slots        (req_used_slots),
      .req_shard             (req_shard),
      .req_live_count        (req_live_count),
      .rsp_valid             (rsp_valid),
      .rsp_level             (rsp_level),
      .rsp_level_changed     (rsp_level_changed),
      .rsp_debt_value        (rsp_debt_value),
      .rsp_repay_request     (rsp_repay_request),
      .rsp_epoch_due         (rsp_epoch_due),
      .rsp_compact_hard      (rsp_compact_hard),
      .rsp_compact_soft      (rsp_compact_soft),
      .rsp_reclaim_segments  (rsp_reclaim_segments),
      .rsp_medium_subrelease (rsp_medium_subrelease)
   );

endmodule

`default_nettype wire

### verif/tb_retention_watermark_debt_policy_unit.sv
`timescale 1ns / 100ps
// self-checking testbench for retention_watermark_debt_policy_unit: directed table,
// register sweeps, debt build-up and random traffic against an in-bench predictor
// depends on rwdp_pkg and the rtl of the unit, nothing else

module tb_retention_watermark_debt_policy_unit;
   import rwdp_pkg::*;

   localparam int CYCLE_LIMIT      = 200_000;
   localparam int RANDOM_PER_PHASE = 92;
   localparam int SETTLE_CYCLES    = 8;
   localparam int MAX_PRINTED      = 20;
   localparam int DEBT_SHARD       = 5;
   localparam int DEBT_RUN         = 10;
   localparam int COLLISION_ABOVE  = 1;

   // command and register codes outside the defined lists
   localparam logic [CMD_W-1:0]     CMD_RSVD_FIRST = 3'd5;
   localparam logic [CMD_W-1:0]     CMD_RSVD_LAST  = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_RSVD_FIRST = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_RSVD_LAST  = 3'd7;

   localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};
   localparam bit TYPED     = 1'b1;
   localparam bit PREDICTED = 1'b0;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [SLOTS_W-1:0] slots;
      logic [SHARD_W-1:0] shard;
      logic [LIVE_W-1:0]  live;
   } policy_item_t;

   // field order matches the result ports, top to bottom
   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic               changed;
      logic [DEBT_W-1:0]  debt;
      logic               repay_request;
      logic               epoch_due;
      logic               compact_hard;
      logic               compact_soft;
      logic               reclaim;
      logic               subrelease;
   } policy_result_t;

   typedef struct packed {
      policy_item_t   item;
      logic           typed;
      policy_result_t outcome;
   } directed_row_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [CMD_W-1:0]     req_cmd = '0;
   logic [SLOTS_W-1:0]   req_used_slots = '0;
   logic [SHARD_W-1:0]   req_shard = '0;
   logic [LIVE_W-1:0]    req_live_count = '0;
   logic                 rsp_valid;
   logic [LEVEL_W-1:0]   rsp_level;
   logic                 rsp_level_changed;
   logic [DEBT_W-1:0]    rsp_debt_value;
   logic                 rsp_repay_request;
   logic                 rsp_epoch_due;
   logic                 rsp_compact_hard;
   logic                 rsp_compact_soft;
   logic                 rsp_reclaim_segments;
   logic                 rsp_medium_subrelease;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [BYTES_W-1:0]   csr_wdata = '0;

   // predictor state: level, per-shard debt, both phases and the live registers
   logic [LEVEL_W-1:0] model_level;
   logic [DEBT_W-1:0]  model_debt [NUM_SHARDS];
   logic [PHASE_W-1:0] model_epoch_phase;
   logic [ROUND_W-1:0] model_round_phase;
   cfg_type            model_cfg;

   policy_result_t pending_outcomes[$];
   directed_row_t  directed_rows[$];

   int cycle_count    = 0;
   int items_sent     = 0;
   int checked_count  = 0;
   int mismatch_count = 0;
   int settings_count = 1;
   int burst_left     = 0;
   int level_changes  = 0;
   int repay_requests = 0;
   int repay_rounds   = 0;
   int subreleases    = 0;

   retention_watermark_debt_policy_unit u_top (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_cmd               (req_cmd),
      .req_used_slots        (req_used_slots),
      .req_shard             (req_shard),
      .req_live_count        (req_live_count),
      .rsp_valid             (rsp_valid),
      .rsp_level             (rsp_level),
      .rsp_level_changed     (rsp_level_changed),
      .rsp_debt_value        (rsp_debt_value),
      .rsp_repay_request     (rsp_repay_request),
      .rsp_epoch_due         (rsp_epoch_due),
      .rsp_compact_hard      (rsp_compact_hard),
      .rsp_compact_soft      (rsp_compact_soft),
      .rsp_reclaim_segments  (rsp_reclaim_segments),
      .rsp_medium_subrelease (rsp_medium_subrelease),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // watchdog, far above the slowest correct run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timed out after %0d cycles, %0d results outstanding",
                  cycle_count, pending_outcomes.size());
         $display("FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   // threshold minus hysteresis, held at zero instead of wrapping
   function automatic logic [BYTES_W-1:0] floor_sub(logic [BYTES_W-1:0] a,
                                                    logic [BYTES_W-1:0] b);
      return (a > b) ? a - b : '0;
   endfunction

   function automatic logic [BYTES_W-1:0] slot_bytes(int slots);
      logic [BYTES_W-1:0] b;
      b = BYTES_W'(slots);
      return b << SEGMENT_SIZE_LOG2;
   endfunction

   function automatic logic [LEVEL_W-1:0] level_after_tick(logic [LEVEL_W-1:0] old,
                                                           logic [BYTES_W-1:0] bytes);
      logic [BYTES_W-1:0] soft_t;
      logic [BYTES_W-1:0] hard_t;
      logic [BYTES_W-1:0] soft_low;
      logic [BYTES_W-1:0] hard_low;
      logic [LEVEL_W-1:0] lv;
      soft_t   = model_cfg.soft_threshold;
      hard_t   = model_cfg.hard_threshold;
      soft_low = floor_sub(model_cfg.soft_threshold, model_cfg.hysteresis);
      hard_low = floor_sub(model_cfg.hard_threshold, model_cfg.hysteresis);
      lv = old;
      case (old)
         LEVEL_L0: begin
            if (bytes >= hard_t) lv = LEVEL_L2;
            else if (bytes >= soft_t) lv = LEVEL_L1;
         end
         LEVEL_L1: begin
            if (bytes >= hard_t) lv = LEVEL_L2;
            else if (bytes < soft_low) lv = LEVEL_L0;
         end
         LEVEL_L2: begin
            // falling below the soft floor wins over the step to L1
            if (bytes < hard_low) lv = LEVEL_L1;
            if (bytes < soft_low) lv = LEVEL_L0;
         end
         default: ;
      endcase
      return lv;
   endfunction

   // applies one item to the predictor state and returns its result
   function automatic policy_result_t advance_policy(policy_item_t it);
      policy_result_t         r;
      logic [BYTES_W-1:0]     bytes;
      logic [LEVEL_W-1:0]     nl;
      logic                   in_range;
      logic [SHARD_IDX_W-1:0] idx;
      logic                   collide;
      int                     interval;
      int                     step;
      r = '0;
      in_range = it.shard < NUM_SHARDS;
      idx = it.shard[SHARD_IDX_W-1:0];
      case (it.cmd)
         CMD_TICK: begin
            bytes = slot_bytes(int'(it.slots));
            nl = level_after_tick(model_level, bytes);
            r.changed = (nl != model_level);
            model_level = nl;
         end
         CMD_OPEN: begin
            if (in_range && model_debt[idx] != DEBT_MAX)
               model_debt[idx] = model_debt[idx] + DEBT_W'(1);
         end
         CMD_FREE: begin
            if (in_range && model_debt[idx] != '0)
               model_debt[idx] = model_debt[idx] - DEBT_W'(1);
         end
         CMD_EPOCH: begin
            // outside L2 an epoch moves nothing
            if (model_level == LEVEL_L2) begin
               interval = (model_cfg.repay_interval == '0) ? 1 : int'(model_cfg.repay_interval);
               step = int'(model_epoch_phase) + 1;
               // a phase left above a lowered bound fires on its next step
               if (step >= interval) begin
                  collide = it.live > COLLISION_ABOVE;
                  model_epoch_phase = '0;
                  r.epoch_due    = 1'b1;
                  r.compact_hard = !collide;
                  r.compact_soft = collide;
                  r.reclaim      = !collide;
                  step = int'(model_round_phase) + 1;
                  if (model_cfg.subrelease_multiple == '0 ||
                      step >= int'(model_cfg.subrelease_multiple)) begin
                     model_round_phase = '0;
                     r.subrelease = !collide;
                  end else begin
                     model_round_phase = step[ROUND_W-1:0];
                  end
               end else begin
                  model_epoch_phase = step[PHASE_W-1:0];
               end
            end
         end
         default: ;
      endcase
      // out-of-range shards read as zero debt, so a query there never asks for repay
      r.debt = in_range ? model_debt[idx] : '0;
      r.repay_request = (it.cmd == CMD_QUERY) && (model_level == LEVEL_L2) &&
                        (r.debt > model_cfg.debt_cap);
      r.level = model_level;
      return r;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic flag_mismatch(string what, longint got, longint want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("mismatch at result %0d: %s is %0h, expected %0h",
                  checked_count, what, got, want);
   endtask

   // results are strobed for one cycle and cannot be held off
   always @(posedge clock) begin : result_check
      policy_result_t seen;
      policy_result_t wanted;
      if (!reset && rsp_valid) begin
         seen = {rsp_level, rsp_level_changed, rsp_debt_value, rsp_repay_request,
                 rsp_epoch_due, rsp_compact_hard, rsp_compact_soft,
                 rsp_reclaim_segments, rsp_medium_subrelease};
         if (pending_outcomes.size() == 0) begin
            flag_mismatch("result with nothing expected", seen, 0);
         end else begin
            wanted = pending_outcomes.pop_front();
            checked_count++;
            if (seen.level !== wanted.level)
               flag_mismatch("level", seen.level, wanted.level);
            if (seen.changed !== wanted.changed)
               flag_mismatch("level_changed", seen.changed, wanted.changed);
            if (seen.debt !== wanted.debt)
               flag_mismatch("debt_value", seen.debt, wanted.debt);
            if (seen.repay_request !== wanted.repay_request)
               flag_mismatch("repay_request", seen.repay_request, wanted.repay_request);
            if (seen.epoch_due !== wanted.epoch_due)
               flag_mismatch("epoch_due", seen.epoch_due, wanted.epoch_due);
            if (seen.compact_hard !== wanted.compact_hard)
               flag_mismatch("compact_hard", seen.compact_hard, wanted.compact_hard);
            if (seen.compact_soft !== wanted.compact_soft)
               flag_mismatch("compact_soft", seen.compact_soft, wanted.compact_soft);
            if (seen.reclaim !== wanted.reclaim)
               flag_mismatch("reclaim_segments", seen.reclaim, wanted.reclaim);
            if (seen.subrelease !== wanted.subrelease)
               flag_mismatch("medium_subrelease", seen.subrelease, wanted.subrelease);
            level_changes  += wanted.changed;
            repay_requests += wanted.repay_request;
            repay_rounds   += wanted.epoch_due;
            subreleases    += wanted.subrelease;
         end
      end
   end

   // ---------------------------------------------------------------- driving

   function automatic policy_item_t make_item(logic [CMD_W-1:0] cmd, int slots,
                                              int shard, int live);
      policy_item_t it;
      it.cmd   = cmd;
      it.slots = slots[SLOTS_W-1:0];
      it.shard = shard[SHARD_W-1:0];
      it.live  = live[LIVE_W-1:0];
      return it;
   endfunction

   // one row of the directed table; flags are all zero where a row is typed
   function automatic directed_row_t make_row(logic [CMD_W-1:0] cmd, int slots, int shard,
                                              int live, bit typed,
                                              logic [LEVEL_W-1:0] level, bit changed,
                                              int debt);
      directed_row_t row;
      row.item            = make_item(cmd, slots, shard, live);
      row.typed           = typed;
      row.outcome         = '0;
      row.outcome.level   = level;
      row.outcome.changed = changed;
      row.outcome.debt    = debt[DEBT_W-1:0];
      return row;
   endfunction

   function automatic cfg_type make_cfg(logic [BYTES_W-1:0] soft_bytes,
                                        logic [BYTES_W-1:0] hard,
                                        logic [BYTES_W-1:0] hyst, logic [DEBT_W-1:0] limit,
                                        logic [PHASE_W-1:0] interval,
                                        logic [ROUND_W-1:0] multiple);
      cfg_type c;
      c.soft_threshold      = soft_bytes;
      c.hard_threshold      = hard;
      c.hysteresis          = hyst;
      c.debt_cap            = limit;
      c.repay_interval      = interval;
      c.subrelease_multiple = multiple;
      return c;
   endfunction

   function automatic logic [BYTES_W-1:0] random_bytes();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[BYTES_W-1:0];
   endfunction

   // start rises at a falling edge and is taken at the first rising edge with busy low;
   // the caller's next falling edge either loads the next item or lowers start
   task automatic send_item(policy_item_t it, bit typed, policy_result_t typed_outcome);
      policy_result_t predicted;
      @(negedge clock);
      start          <= 1'b1;
      req_cmd        <= it.cmd;
      req_used_slots <= it.slots;
      req_shard      <= it.shard;
      req_live_count <= it.live;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = advance_policy(it);
      pending_outcomes.push_back(typed ? typed_outcome : predicted);
      items_sent++;
   endtask

   task automatic idle_cycles(int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   // hold off until every result is back, then let the pipeline settle
   task automatic wait_quiet();
      @(negedge clock);
      start <= 1'b0;
      while (pending_outcomes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // bursts of random length with random gaps, now and then a full drain
   task automatic paced_send(policy_item_t it, bit typed, policy_result_t typed_outcome);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         idle_cycles(gap);
         burst_left = $urandom_range(1, 12);
      end
      if ($urandom_range(0, 49) == 0) wait_quiet();
      send_item(it, typed, typed_outcome);
      burst_left--;
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [BYTES_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_SOFT_THRESHOLD: model_cfg.soft_threshold      = data;
         CSR_HARD_THRESHOLD: model_cfg.hard_threshold      = data;
         CSR_HYSTERESIS:     model_cfg.hysteresis          = data;
         CSR_DEBT_CAP:       model_cfg.debt_cap            = data[DEBT_W-1:0];
         CSR_REPAY_INTERVAL: model_cfg.repay_interval      = data[PHASE_W-1:0];
         CSR_SUBREL_MULT:    model_cfg.subrelease_multiple = data[ROUND_W-1:0];
         default: ;
      endcase
   endtask

   // registers change only with the unit idle; junk to the unused indexes must be dropped
   task automatic program_config(cfg_type c);
      wait_quiet();
      write_csr(CSR_RSVD_FIRST, random_bytes());
      write_csr(CSR_SOFT_THRESHOLD, c.soft_threshold);
      write_csr(CSR_HARD_THRESHOLD, c.hard_threshold);
      write_csr(CSR_HYSTERESIS, c.hysteresis);
      write_csr(CSR_DEBT_CAP, BYTES_W'(c.debt_cap));
      write_csr(CSR_REPAY_INTERVAL, BYTES_W'(c.repay_interval));
      write_csr(CSR_SUBREL_MULT, BYTES_W'(c.subrelease_multiple));
      write_csr(CSR_RSVD_LAST, random_bytes());
      @(negedge clock);
      csr_we <= 1'b0;
      settings_count++;
   endtask

   // mostly hot shards so debt climbs past the limit; ticks mostly land next to a
   // threshold or a hysteresis floor so the level keeps moving
   function automatic policy_item_t random_item();
      policy_item_t       it;
      int                 pick;
      int                 offset;
      logic [BYTES_W-1:0] anchor;
      longint             target;
      pick = $urandom_range(0, 99);
      if (pick < 20) it.cmd = CMD_TICK;
      else if (pick < 45) it.cmd = CMD_OPEN;
      else if (pick < 60) it.cmd = CMD_FREE;
      else if (pick < 75) it.cmd = CMD_QUERY;
      else if (pick < 95) it.cmd = CMD_EPOCH;
      else it.cmd = CMD_W'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));

      pick = $urandom_range(0, 9);
      if (pick < 8) it.shard = SHARD_W'($urandom_range(0, 3));
      else if (pick == 8) it.shard = SHARD_W'($urandom_range(0, NUM_SHARDS - 1));
      else it.shard = SHARD_W'($urandom_range(0, (1 << SHARD_W) - 1));

      it.live = LIVE_W'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 2)
                                                     : $urandom_range(0, (1 << LIVE_W) - 1));

      if ($urandom_range(0, 9) < 4) begin
         it.slots = SLOTS_W'($urandom_range(0, (1 << SLOTS_W) - 1));
      end else begin
         case ($urandom_range(0, 3))
            0: anchor = model_cfg.soft_threshold;
            1: anchor = model_cfg.hard_threshold;
            2: anchor = floor_sub(model_cfg.soft_threshold, model_cfg.hysteresis);
            default: anchor = floor_sub(model_cfg.hard_threshold, model_cfg.hysteresis);
         endcase
         offset = $urandom_range(0, 4);
         target = longint'(anchor >> SEGMENT_SIZE_LOG2) + offset - 2;
         if (target < 0) target = 0;
         if (target > (1 << SLOTS_W) - 1) target = (1 << SLOTS_W) - 1;
         it.slots = target[SLOTS_W-1:0];
      end
      return it;
   endfunction

   task automatic random_traffic(int n);
      repeat (n) paced_send(random_item(), PREDICTED, '0);
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      // predictor starts from the reset state of the unit
      model_level       = LEVEL_L0;
      model_epoch_phase = '0;
      model_round_phase = '0;
      foreach (model_debt[i]) model_debt[i] = '0;
      model_cfg = make_cfg(40'd2147483648, 40'd3221225472, 40'd268435456,
                           16'd4, 16'd16, 8'd4);

      // directed table, run under the reset register values
      // soft threshold is 1024 slots, hard 1536, hysteresis 128
      directed_rows.push_back(make_row(CMD_QUERY, 0, 0, 0, TYPED, LEVEL_L0, 0, 0));
      directed_rows.push_back(make_row(CMD_TICK, 0, 0, 0, TYPED, LEVEL_L0, 0, 0));
      directed_rows.push_back(make_row(CMD_OPEN, 0, 0, 0, TYPED, LEVEL_L0, 0, 1));
      directed_rows.push_back(make_row(CMD_OPEN, 0, NUM_SHARDS - 1, 0, TYPED, LEVEL_L0, 0, 1));
      // out-of-range shards: open and free ignored, debt reads zero
      directed_rows.push_back(make_row(CMD_OPEN, 0, 255, 0, TYPED, LEVEL_L0, 0, 0));
      directed_rows.push_back(make_row(CMD_FREE, 0, NUM_SHARDS, 0, TYPED, LEVEL_L0, 0, 0));
      directed_rows.push_back(make_row(CMD_FREE, 0, NUM_SHARDS - 1, 0, TYPED, LEVEL_L0, 0, 0));
      // free at zero stays at zero
      directed_rows.push_back(make_row(CMD_FREE, 0, NUM_SHARDS - 1, 0, TYPED, LEVEL_L0, 0, 0));
      // unknown commands change nothing
      directed_rows.push_back(make_row(CMD_RSVD_FIRST, 65535, 0, 255, TYPED, LEVEL_L0, 0, 1));
      directed_rows.push_back(make_row(CMD_RSVD_LAST, 0, 255, 0, TYPED, LEVEL_L0, 0, 0));
      // epoch below L2 does nothing
      directed_rows.push_back(make_row(CMD_EPOCH, 0, 3, 255, TYPED, LEVEL_L0, 0, 0));
      // one slot short of soft, then exactly soft, exactly hard, top of range
      directed_rows.push_back(make_row(CMD_TICK, 1023, 0, 0, TYPED, LEVEL_L0, 0, 1));
      directed_rows.push_back(make_row(CMD_TICK, 1024, 0, 0, TYPED, LEVEL_L1, 1, 1));
      directed_rows.push_back(make_row(CMD_TICK, 1536, 0, 0, TYPED, LEVEL_L2, 1, 1));
      directed_rows.push_back(make_row(CMD_TICK, 65535, 0, 0, TYPED, LEVEL_L2, 0, 1));
      directed_rows.push_back(make_row(CMD_EPOCH, 0, 0, 1, PREDICTED, LEVEL_L0, 0, 0));
      directed_rows.push_back(make_row(CMD_QUERY, 0, 0, 0, TYPED, LEVEL_L2, 0, 1));
      directed_rows.push_back(make_row(CMD_QUERY, 0, 200, 0, TYPED, LEVEL_L2, 0, 0));
      // epoch on an out-of-range shard still counts
      directed_rows.push_back(make_row(CMD_EPOCH, 0, 200, 2, PREDICTED, LEVEL_L0, 0, 0));
      // below the hard floor only: down to L1, then back up
      directed_rows.push_back(make_row(CMD_TICK, 1400, 0, 0, PREDICTED, LEVEL_L0, 0, 0));
      directed_rows.push_back(make_row(CMD_TICK, 1536, 0, 0, PREDICTED, LEVEL_L0, 0, 0));
      // below both floors from L2 goes straight to L0
      directed_rows.push_back(make_row(CMD_TICK, 0, 0, 0, TYPED, LEVEL_L0, 1, 1));
      directed_rows.push_back(make_row(CMD_TICK, 1536, 255, 0, TYPED, LEVEL_L2, 1, 0));
      directed_rows.push_back(make_row(CMD_TICK, 43690, 0, 0, TYPED, LEVEL_L2, 0, 1));
      directed_rows.push_back(make_row(CMD_TICK, 21845, 0, 0, TYPED, LEVEL_L2, 0, 1));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         paced_send(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].outcome);
      random_traffic(RANDOM_PER_PHASE);

      // tight window, short interval, subrelease every other round
      program_config(make_cfg(slot_bytes(800), slot_bytes(1200), slot_bytes(100),
                              16'd2, 16'd3, 8'd2));
      random_traffic(RANDOM_PER_PHASE);

      // all zero: any tick means L2, zero interval acts as one, subrelease every round
      program_config(make_cfg('0, '0, '0, '0, '0, '0));
      random_traffic(RANDOM_PER_PHASE);

      // hysteresis above both thresholds clamps the floors at zero, so L2 sticks;
      // phases build up here for the next setting
      program_config(make_cfg(slot_bytes(300), slot_bytes(600), slot_bytes(700),
                              16'd1, 16'd4, 8'd8));
      random_traffic(RANDOM_PER_PHASE);

      // interval and multiple lowered under running phases
      program_config(make_cfg(slot_bytes(300), slot_bytes(600), slot_bytes(50),
                              16'd3, 16'd2, 8'd1));
      random_traffic(RANDOM_PER_PHASE);

      // every register at its top value
      program_config(make_cfg(BYTES_MAX, BYTES_MAX, BYTES_MAX, DEBT_MAX, {PHASE_W{1'b1}},
                              {ROUND_W{1'b1}}));
      random_traffic(RANDOM_PER_PHASE);

      // build one shard's debt past a small limit, ask for repay, then free it past zero
      program_config(make_cfg('0, '0, '0, 16'd6, 16'd1, 8'd3));
      send_item(make_item(CMD_TICK, 0, DEBT_SHARD, 0), PREDICTED, '0);
      repeat (DEBT_RUN) send_item(make_item(CMD_OPEN, 0, DEBT_SHARD, 0), PREDICTED, '0);
      send_item(make_item(CMD_QUERY, 0, DEBT_SHARD, 0), PREDICTED, '0);
      repeat (DEBT_RUN + 2)
         send_item(make_item(CMD_FREE, 0, DEBT_SHARD, 0), PREDICTED, '0);
      send_item(make_item(CMD_QUERY, 0, DEBT_SHARD, 0), PREDICTED, '0);
      random_traffic(RANDOM_PER_PHASE);

      // random setting with ragged low bits on the thresholds
      program_config(make_cfg(
         slot_bytes($urandom_range(0, 3000)) | BYTES_W'($urandom_range(0, 2097151)),
         slot_bytes($urandom_range(1500, 4000)) | BYTES_W'($urandom_range(0, 2097151)),
         slot_bytes($urandom_range(0, 400)) | BYTES_W'($urandom_range(0, 2097151)),
         DEBT_W'($urandom_range(0, 8)), PHASE_W'($urandom_range(1, 6)),
         ROUND_W'($urandom_range(0, 5))));
      random_traffic(RANDOM_PER_PHASE);

      wait_quiet();
      $display("%0d items over %0d register settings, %0d results checked",
               items_sent, settings_count, checked_count);
      $display("%0d level changes, %0d repay requests, %0d repay rounds, %0d subreleases",
               level_changes, repay_requests, repay_rounds, subreleases);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### files.f
rtl/rwdp_pkg.sv
rtl/rwdp_csr.sv
rtl/rwdp_ctrl.sv
rtl/rwdp_datapath.sv
rtl/retention_watermark_debt_policy_unit.sv
verif/tb_retention_watermark_debt_policy_unit.sv
